### src/cau_pkg.sv
`default_nettype none
package cau_pkg;
  localparam int unsigned PartWidth    = 16;
  localparam int unsigned FractionBits = 8;

  localparam logic [1:0] ModeAdd = 2'd0;
  localparam logic [1:0] ModeSub = 2'd1;
  localparam logic [1:0] ModeMul = 2'd2;
  localparam logic [1:0] ModeDiv = 2'd3;
endpackage
`default_nettype wire

### src/cau_div_cell.sv
`default_nettype none
// One restoring-division step for two quotients that share one denominator.
// Each cell produces one quotient bit per part and hands everything to the next cell.
module cau_div_cell #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 33,
  parameter int unsigned QW   = 26,
  parameter int unsigned SbW  = 38
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            stall_i,
  input  wire logic            vld_i,
  input  wire logic [SbW-1:0]  side_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [NumW-1:0] nr_i,
  input  wire logic [NumW-1:0] ni_i,
  input  wire logic [DenW:0]   rr_i,
  input  wire logic [DenW:0]   ri_i,
  input  wire logic [QW-1:0]   qr_i,
  input  wire logic [QW-1:0]   qi_i,
  output logic                 vld_o,
  output logic [SbW-1:0]       side_o,
  output logic [DenW-1:0]      den_o,
  output logic [NumW-1:0]      nr_o,
  output logic [NumW-1:0]      ni_o,
  output logic [DenW:0]        rr_o,
  output logic [DenW:0]        ri_o,
  output logic [QW-1:0]        qr_o,
  output logic [QW-1:0]        qi_o
);
  logic [DenW+1:0] tr, ti;
  logic            ger, gei;
  logic            vld_q;
  logic [SbW-1:0]  side_q;
  logic [DenW-1:0] den_q;
  logic [NumW-1:0] nr_q, ni_q;
  logic [DenW:0]   rr_q, ri_q;
  logic [QW-1:0]   qr_q, qi_q;

  always_comb begin
    tr  = {rr_i, nr_i[NumW-1]};
    ti  = {ri_i, ni_i[NumW-1]};
    ger = (tr >= {2'b00, den_i});
    gei = (ti >= {2'b00, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!stall_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      side_q <= side_i;
      den_q  <= den_i;
      nr_q   <= {nr_i[NumW-2:0], 1'b0};
      ni_q   <= {ni_i[NumW-2:0], 1'b0};
      rr_q   <= ger ? (DenW+1)'(tr - {2'b00, den_i}) : tr[DenW:0];
      ri_q   <= gei ? (DenW+1)'(ti - {2'b00, den_i}) : ti[DenW:0];
      qr_q   <= {qr_i[QW-2:0], ger};
      qi_q   <= {qi_i[QW-2:0], gei};
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign den_o  = den_q;
  assign nr_o   = nr_q;
  assign ni_o   = ni_q;
  assign rr_o   = rr_q;
  assign ri_o   = ri_q;
  assign qr_o   = qr_q;
  assign qi_o   = qi_q;
endmodule
`default_nettype wire

### src/complex_arithmetic_unit_core.sv
`default_nettype none
// Channel | direction | valid    | stall    | payload
// in      | to core   | valid_i  | stall_o  | mode_i, left_*_i, right_*_i
// out     | from core | valid_o  | stall_i  | out_real_o, out_imag_o, overflow_o,
//         |           |          |          | divide_by_zero_o
//
// One beat in per cycle while stall_i is low. Every beat takes the same path:
// one product stage, one sum stage, one division cell per quotient bit
// (2*PART_WIDTH+1+FRACTION_BITS), then a rounding and a saturation stage. The
// whole pipe holds on stall_i; stall_o is stall_i, the output register keeps the
// last beat stable. Reset clears the valid bits only; payload is not reset.
module complex_arithmetic_unit_core #(
  parameter int unsigned PART_WIDTH    = cau_pkg::PartWidth,
  parameter int unsigned FRACTION_BITS = cau_pkg::FractionBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              stall_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic signed [PART_WIDTH-1:0] left_real_i,
  input  wire logic signed [PART_WIDTH-1:0] left_imag_i,
  input  wire logic signed [PART_WIDTH-1:0] right_real_i,
  input  wire logic signed [PART_WIDTH-1:0] right_imag_i,
  output logic                              valid_o,
  input  wire logic                         stall_i,
  output logic signed [PART_WIDTH-1:0]      out_real_o,
  output logic signed [PART_WIDTH-1:0]      out_imag_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o
);
  localparam int unsigned W    = PART_WIDTH;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned PW   = 2 * W;          // product magnitude
  localparam int unsigned SW   = PW + 2;         // signed sum of two products
  localparam int unsigned NumW = PW + 1;         // numerator magnitude
  localparam int unsigned DenW = PW + 1;         // squared magnitude
  localparam int unsigned NCell = NumW + F;      // quotient bits computed
  localparam int unsigned QW   = NCell;
  localparam int unsigned SbW  = 4;              // mode, signs

  wire logic adv = !stall_i;
  assign stall_o = stall_i;

  // Stage 1: four products and two squares, signed, plus the sum or difference for add and subtract.
  logic                  v1_q;
  logic [1:0]            m1_q;
  logic signed [PW-1:0]  ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic signed [W:0]     sr_q, si_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q <= mode_i;
      ac_q <= left_real_i * right_real_i;
      bd_q <= left_imag_i * right_imag_i;
      ad_q <= left_real_i * right_imag_i;
      bc_q <= left_imag_i * right_real_i;
      cc_q <= right_real_i * right_real_i;
      dd_q <= right_imag_i * right_imag_i;
      if (mode_i == cau_pkg::ModeSub) begin
        sr_q <= (W+1)'(left_real_i) - (W+1)'(right_real_i);
        si_q <= (W+1)'(left_imag_i) - (W+1)'(right_imag_i);
      end else begin
        sr_q <= (W+1)'(left_real_i) + (W+1)'(right_real_i);
        si_q <= (W+1)'(left_imag_i) + (W+1)'(right_imag_i);
      end
    end
  end

  // Stage 2: numerators and denominator, split into sign and magnitude.
  logic signed [SW-1:0] nr_s, ni_s;
  logic [DenW-1:0]      den_c;
  always_comb begin
    if (m1_q == cau_pkg::ModeMul) begin
      nr_s = SW'(ac_q) - SW'(bd_q);
      ni_s = SW'(ad_q) + SW'(bc_q);
    end else if (m1_q == cau_pkg::ModeDiv) begin
      nr_s = SW'(ac_q) + SW'(bd_q);
      ni_s = SW'(bc_q) - SW'(ad_q);
    end else begin
      nr_s = SW'(sr_q);
      ni_s = SW'(si_q);
    end
    den_c = DenW'($unsigned(cc_q)) + DenW'($unsigned(dd_q));
  end

  logic            v2_q;
  logic [SbW-1:0]  sb2_q;
  logic [DenW-1:0] den2_q;
  logic [NumW-1:0] nr2_q, ni2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb2_q  <= {m1_q, nr_s[SW-1], ni_s[SW-1]};
      den2_q <= (den_c == '0) ? DenW'(1) : den_c;
      nr2_q  <= NumW'(nr_s[SW-1] ? -nr_s : nr_s);
      ni2_q  <= NumW'(ni_s[SW-1] ? -ni_s : ni_s);
    end
  end

  // Zero-divisor flag, registered alongside stage 2.
  logic dzm2_q;
  always_ff @(posedge clk_i) begin
    if (adv) dzm2_q <= (m1_q == cau_pkg::ModeDiv) && (den_c == '0);
  end

  // Division chain. Non-divide modes run through it too; their result is taken
  // from the delay line below. A zero divisor is replaced by one.
  logic            cv   [NCell+1];
  logic [SbW-1:0]  csb  [NCell+1];
  logic [DenW-1:0] cden [NCell+1];
  logic [NumW-1:0] cnr  [NCell+1];
  logic [NumW-1:0] cni  [NCell+1];
  logic [DenW:0]   crr  [NCell+1];
  logic [DenW:0]   cri  [NCell+1];
  logic [QW-1:0]   cqr  [NCell+1];
  logic [QW-1:0]   cqi  [NCell+1];

  // The original magnitudes ride along in a delay line for non-divide modes.
  logic [NumW-1:0] hr_q [NCell];
  logic [NumW-1:0] hi_q [NCell];
  logic            hz_q [NCell];

  assign cv[0]   = v2_q;
  assign csb[0]  = sb2_q;
  assign cden[0] = den2_q;
  assign cnr[0]  = nr2_q;
  assign cni[0]  = ni2_q;
  assign crr[0]  = '0;
  assign cri[0]  = '0;
  assign cqr[0]  = '0;
  assign cqi[0]  = '0;

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    cau_div_cell #(.NumW(NumW), .DenW(DenW), .QW(QW), .SbW(SbW)) u_cell (
      .clk_i, .rst_ni, .stall_i,
      .vld_i(cv[g]), .side_i(csb[g]), .den_i(cden[g]), .nr_i(cnr[g]), .ni_i(cni[g]),
      .rr_i(crr[g]), .ri_i(cri[g]), .qr_i(cqr[g]), .qi_i(cqi[g]),
      .vld_o(cv[g+1]), .side_o(csb[g+1]), .den_o(cden[g+1]), .nr_o(cnr[g+1]),
      .ni_o(cni[g+1]), .rr_o(crr[g+1]), .ri_o(cri[g+1]), .qr_o(cqr[g+1]),
      .qi_o(cqi[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hr_q[0] <= nr2_q;
      hi_q[0] <= ni2_q;
      hz_q[0] <= dzm2_q;
      for (int k = 1; k < NCell; k++) begin
        hr_q[k] <= hr_q[k-1];
        hi_q[k] <= hi_q[k-1];
        hz_q[k] <= hz_q[k-1];
      end
    end
  end

  // Rounding stage.
  logic [1:0]      mt;
  logic            snr, sni, dzt;
  logic [QW:0]     rre, rim;
  logic [NumW:0]   pre, pim;
  logic [DenW:0]   dtl;
  assign mt  = csb[NCell][3:2];
  assign snr = csb[NCell][1];
  assign sni = csb[NCell][0];
  assign dzt = hz_q[NCell-1];
  assign dtl = {1'b0, cden[NCell]};

  always_comb begin
    rre = {1'b0, cqr[NCell]} + (QW+1)'((crr[NCell] >= dtl - crr[NCell]) ? 1 : 0);
    rim = {1'b0, cqi[NCell]} + (QW+1)'((cri[NCell] >= dtl - cri[NCell]) ? 1 : 0);
    if (F > 0) begin
      pre = ({1'b0, hr_q[NCell-1]} + (NumW+1)'(F > 0 ? (1 << (F - 1)) : 0)) >> F;
      pim = ({1'b0, hi_q[NCell-1]} + (NumW+1)'(F > 0 ? (1 << (F - 1)) : 0)) >> F;
    end else begin
      pre = {1'b0, hr_q[NCell-1]};
      pim = {1'b0, hi_q[NCell-1]};
    end
  end

  localparam int unsigned MW = QW + 1;
  logic            v3_q, sr3_q, si3_q, dz3_q;
  logic [MW-1:0]   mr3_q, mi3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= cv[NCell];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr3_q <= snr;
      si3_q <= sni;
      dz3_q <= dzt;
      if (dzt) begin
        mr3_q <= '0;
        mi3_q <= '0;
      end else if (mt == cau_pkg::ModeDiv) begin
        mr3_q <= rre;
        mi3_q <= rim;
      end else if (mt == cau_pkg::ModeMul) begin
        mr3_q <= MW'(pre);
        mi3_q <= MW'(pim);
      end else begin
        mr3_q <= MW'(hr_q[NCell-1]);
        mi3_q <= MW'(hi_q[NCell-1]);
      end
    end
  end

  // Saturation and output register.
  localparam logic [MW-1:0] Half = MW'(1) << (W - 1);
  logic [W-1:0] or_c, oi_c;
  logic         ovr, ovi;
  always_comb begin
    if (sr3_q) begin
      ovr  = mr3_q > Half;
      or_c = ovr ? W'(Half) : W'(-mr3_q);
    end else begin
      ovr  = mr3_q > Half - MW'(1);
      or_c = ovr ? W'(Half - MW'(1)) : W'(mr3_q);
    end
    if (si3_q) begin
      ovi  = mi3_q > Half;
      oi_c = ovi ? W'(Half) : W'(-mi3_q);
    end else begin
      ovi  = mi3_q > Half - MW'(1);
      oi_c = ovi ? W'(Half - MW'(1)) : W'(mi3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_real_o       <= or_c;
      out_imag_o       <= oi_c;
      overflow_o       <= ovr | ovi;
      divide_by_zero_o <= dz3_q;
    end
  end

  // Shifted-out numerators at the chain's end are not needed.
  logic unused;
  assign unused = ^{cnr[NCell], cni[NCell]};
endmodule
`default_nettype wire
